// ----- rtl/core/round_robin_task_checkin_watchdog_defines.svh -----
// Assertion macros for the round-robin task check-in watchdog.
// Included by the modules that carry concurrent assertions; needs clock and reset in scope.
`ifndef ROUND_ROBIN_TASK_CHECKIN_WATCHDOG_DEFINES_SVH
`define ROUND_ROBIN_TASK_CHECKIN_WATCHDOG_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RRTCW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RRTCW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/rrtcw_pkg.sv -----
// Shared constants, codes and types of the task check-in watchdog.
// Used by rrtcw_cell and round_robin_task_checkin_watchdog; depends on nothing.
`default_nettype none

package rrtcw_pkg;

   localparam int MAX_TASKS   = 20;
   localparam int HANDLE_BITS = 32;
   localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W       = $clog2(MAX_TASKS + 1);
   localparam int TOL_W       = 8;

   localparam logic [31:0] DEFAULT_PERIOD = 32'd15000;

   // Operation codes of a request.
   localparam logic [2:0] OP_REGISTER     = 3'd0;
   localparam logic [2:0] OP_REGISTER_TOL = 3'd1;
   localparam logic [2:0] OP_REMOVE       = 3'd2;
   localparam logic [2:0] OP_CHECKIN      = 3'd3;
   localparam logic [2:0] OP_URGENT       = 3'd4;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISSED   = 2'd1;
   localparam logic [1:0] STATUS_FAULT    = 2'd2;
   localparam logic [1:0] STATUS_REJECTED = 2'd3;

   // Table update commands broadcast to the cells.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_APPEND  = 2'd1;
   localparam logic [1:0] CMD_SET_TOL = 2'd2;
   localparam logic [1:0] CMD_REMOVE  = 2'd3;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [TOL_W-1:0]       tol;
      logic [IDX_W-1:0]       seq;
   } entry_type;

   // Query token that walks the chain one cell per cycle.
   typedef struct packed {
      logic [HANDLE_BITS-1:0] query;
      logic [IDX_W-1:0]       turn;
      logic                   found;
      logic [IDX_W-1:0]       found_pos;
      logic                   matched;
      logic                   turn_occupied;
      logic [TOL_W-1:0]       turn_tol;
   } token_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [IDX_W-1:0]       pos;
      logic [HANDLE_BITS-1:0] handle;
      logic [TOL_W-1:0]       tol;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/core/rrtcw_cell.sv -----
// One table slot of the watchdog: holds an entry and forwards the query token.
// Depends on rrtcw_pkg for the entry, token and command types.
`default_nettype none

module rrtcw_cell
   import rrtcw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire token_type        tok_in,
   output token_type             tok_out,
   input  wire cmd_type          cmd,
   input  wire entry_type        next_entry,
   output entry_type             entry_out
);

   entry_type entry_ff;
   entry_type entry_in;
   token_type tok_ff;
   token_type tok_in_n;
   logic      hit;

   assign hit = (entry_ff.handle != '0) && (entry_ff.handle == tok_in.query);

   always_comb begin
      tok_in_n = tok_in;
      if (hit && !tok_in.found) begin
         tok_in_n.found     = 1'b1;
         tok_in_n.found_pos = cell_idx;
      end
      if (hit && (entry_ff.seq == tok_in.turn)) begin
         tok_in_n.matched = 1'b1;
      end
      if (cell_idx == tok_in.turn) begin
         tok_in_n.turn_occupied = (entry_ff.handle != '0);
         tok_in_n.turn_tol      = entry_ff.tol;
      end
   end

   // A remove pulls every slot from the removed position upward from its neighbor;
   // slots beyond the count are empty, so the last live slot ends up cleared.
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.kind)
         CMD_NONE: begin
         end
         CMD_APPEND: begin
            if (cell_idx == cmd.pos) begin
               entry_in.handle = cmd.handle;
               entry_in.tol    = cmd.tol;
               entry_in.seq    = cmd.pos;
            end
         end
         CMD_SET_TOL: begin
            if (cell_idx == cmd.pos) begin
               entry_in.tol = cmd.tol;
            end
         end
         CMD_REMOVE: begin
            if (cell_idx >= cmd.pos) begin
               entry_in = next_entry;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         tok_ff   <= '0;
      end else begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in_n;
      end
   end

   assign tok_out   = tok_ff;
   assign entry_out = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/core/round_robin_task_checkin_watchdog.sv -----
// Requests are taken only in idle: the query token walks the 20-cell chain one cell
// per cycle, then the decide state commits the table update and the response, waiting
// while rsp_stall holds a pending response; req_stall stays high until that commit.
// Reset (synchronous, active high) empties the table, clears turn, miss count and
// fault latch, and sets the timeout period to 15000; there is no clearing pass.
// Depends on rrtcw_pkg, rrtcw_cell and the assertion macro header.
`default_nettype none
`include "round_robin_task_checkin_watchdog_defines.svh"

module round_robin_task_checkin_watchdog
   import rrtcw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_task_handle,
   input  wire logic [7:0]  req_tolerance,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_feed_watchdog,
   output logic             rsp_reboot_request,
   output logic             rsp_error_flag,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_timeout_period
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;

   logic [2:0]             op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [TOL_W-1:0]       tol_ff;
   logic [31:0]            now_ff;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       turn_ff, turn_in;
   logic [31:0]            last_feed_ff, last_feed_in;
   logic [TOL_W-1:0]       miss_ff, miss_in;
   logic                   fault_ff, fault_in;
   logic                   reboot_ff, reboot_in;
   logic [31:0]            period_ff;
   logic                   expired_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff, status_in;
   logic                   rsp_feed_ff, feed_in;

   logic                   accept;
   logic                   commit;
   logic [32:0]            elapsed;
   logic [TOL_W:0]         miss_inc;
   logic [CNT_W:0]         turn_next;
   logic [IDX_W-1:0]       turn_adv;
   cmd_type                cmd_dec, cmd_bus;

   token_type              tok_chain [MAX_TASKS+1];
   entry_type              entries   [MAX_TASKS+1];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign commit    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   // Query token entering the first cell; it is stable for the whole scan.
   always_comb begin
      tok_chain[0]               = '0;
      tok_chain[0].query         = handle_ff;
      tok_chain[0].turn          = turn_ff;
   end
   assign entries[MAX_TASKS] = '0;

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         rrtcw_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_idx   (IDX_W'(g)),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .cmd        (cmd_bus),
            .next_entry (entries[g+1]),
            .entry_out  (entries[g])
         );
      end
   endgenerate

   // A last feed time later than now counts as now, which can never expire.
   assign elapsed   = {1'b0, now_ff} - {1'b0, last_feed_ff};
   assign miss_inc  = {1'b0, miss_ff} + {{TOL_W{1'b0}}, 1'b1};
   assign turn_next = {{(CNT_W+1-IDX_W){1'b0}}, turn_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign turn_adv  = (turn_next >= {1'b0, count_ff}) ? '0 : turn_next[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            if (scan_cnt_ff == CNT_W'(MAX_TASKS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      token_type tok;
      tok          = tok_chain[MAX_TASKS];
      cmd_dec      = '0;
      cmd_dec.kind = CMD_NONE;
      status_in    = STATUS_REJECTED;
      feed_in      = 1'b0;
      count_in     = count_ff;
      turn_in      = turn_ff;
      last_feed_in = last_feed_ff;
      miss_in      = miss_ff;
      fault_in     = fault_ff;
      reboot_in    = reboot_ff;
      unique case (op_ff)
         OP_REGISTER, OP_REGISTER_TOL: begin
            if (handle_ff != '0) begin
               if (tok.found) begin
                  if (op_ff == OP_REGISTER_TOL) begin
                     cmd_dec.kind = CMD_SET_TOL;
                     cmd_dec.pos  = tok.found_pos;
                     cmd_dec.tol  = tol_ff;
                  end
                  status_in = STATUS_OK;
               end else if (count_ff < CNT_W'(MAX_TASKS)) begin
                  cmd_dec.kind   = CMD_APPEND;
                  cmd_dec.pos    = count_ff[IDX_W-1:0];
                  cmd_dec.handle = handle_ff;
                  cmd_dec.tol    = (op_ff == OP_REGISTER_TOL) ? tol_ff : '0;
                  count_in       = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                  status_in      = STATUS_OK;
               end
            end
         end
         OP_REMOVE: begin
            if ((handle_ff != '0) && (count_ff != '0) && tok.found) begin
               cmd_dec.kind = CMD_REMOVE;
               cmd_dec.pos  = tok.found_pos;
               count_in     = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
               status_in    = STATUS_OK;
            end
         end
         OP_CHECKIN, OP_URGENT: begin
            if ((op_ff == OP_URGENT) || (count_ff == '0) || tok.matched) begin
               last_feed_in = now_ff;
               feed_in      = 1'b1;
               miss_in      = '0;
               fault_in     = 1'b0;
               reboot_in    = 1'b0;
               status_in    = STATUS_OK;
               if ((op_ff != OP_URGENT) && (count_ff != '0)) begin
                  turn_in = turn_adv;
               end
            end else if (expired_ff) begin
               last_feed_in = now_ff;
               feed_in      = 1'b1;
               if (miss_inc > {1'b0, tok.turn_tol}) begin
                  fault_in  = 1'b1;
                  miss_in   = tok.turn_tol;
                  reboot_in = 1'b1;
                  status_in = STATUS_FAULT;
               end else begin
                  miss_in   = miss_inc[TOL_W-1:0];
                  reboot_in = 1'b0;
                  status_in = STATUS_MISSED;
               end
            end else if (!tok.turn_occupied) begin
               // The turn slot is empty: skip it as if its task had checked in.
               last_feed_in = now_ff;
               feed_in      = 1'b1;
               miss_in      = '0;
               fault_in     = 1'b0;
               reboot_in    = 1'b0;
               cmd_dec.kind = CMD_SET_TOL;
               cmd_dec.pos  = turn_ff;
               cmd_dec.tol  = '0;
               turn_in      = turn_adv;
               status_in    = STATUS_OK;
            end else begin
               if (last_feed_ff > now_ff) begin
                  last_feed_in = now_ff;
               end
               reboot_in = fault_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd_bus = cmd_dec;
      if (!commit) begin
         cmd_bus      = '0;
         cmd_bus.kind = CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         count_ff     <= '0;
         turn_ff      <= '0;
         last_feed_ff <= '0;
         miss_ff      <= '0;
         fault_ff     <= 1'b0;
         reboot_ff    <= 1'b0;
         period_ff    <= DEFAULT_PERIOD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_timeout_period;
         end
         if (commit) begin
            count_ff     <= count_in;
            turn_ff      <= turn_in;
            last_feed_ff <= last_feed_in;
            miss_ff      <= miss_in;
            fault_ff     <= fault_in;
            reboot_ff    <= reboot_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         handle_ff <= HANDLE_BITS'(req_task_handle);
         tol_ff    <= req_tolerance;
         now_ff    <= req_now;
      end
      if (state_ff == ST_SCAN) begin
         expired_ff <= !elapsed[32] && (elapsed[31:0] > period_ff);
      end
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_feed_ff   <= feed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_feed_watchdog  = rsp_feed_ff;
   assign rsp_reboot_request = reboot_ff;
   assign rsp_error_flag     = fault_ff;

   `RRTCW_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_TASKS), "entry count above table size")
   `RRTCW_ASSERT_IMP(a_reboot_needs_fault, reboot_ff, fault_ff, "reboot requested without a latched fault")
   `RRTCW_ASSERT_NXT(a_accept_scans, accept, (state_ff == ST_SCAN) && (scan_cnt_ff == '0), "accepted transaction did not start a scan")
   `RRTCW_ASSERT_NXT(a_commit_responds, commit, rsp_valid_ff && (state_ff == ST_IDLE), "committed transaction produced no response")

endmodule

`default_nettype wire
